FILE: hdl/dapc_pkg.sv
// Shared types and constants of the two-axis PD attitude controller.
package dapc_pkg;

  // Fixed-point formats.
  localparam int GAIN_FRAC_BITS  = 12;
  localparam int ALPHA_FRAC_BITS = 12;
  localparam logic [12:0] ALPHA_ONE = 13'd4096;

  // Shared multiplier operand and product widths.
  localparam int OPA_W  = 33;
  localparam int OPB_W  = 21;
  localparam int PROD_W = 50;
  localparam logic signed [OPB_W-1:0] US_PER_S = 21'sd1000000;

  // Divider: magnitude of the scaled error difference, two quotient bits per cycle.
  localparam int DIV_W     = 38;
  localparam int DVS_W     = 16;
  localparam int DIV_ITER  = DIV_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // Register indexes, byte address is four times the index.
  localparam logic [2:0] REG_KP_ROLL      = 3'd0;
  localparam logic [2:0] REG_KP_PITCH     = 3'd1;
  localparam logic [2:0] REG_KD_ROLL      = 3'd2;
  localparam logic [2:0] REG_KD_PITCH     = 3'd3;
  localparam logic [2:0] REG_FILTER_ALPHA = 3'd4;
  localparam logic [2:0] REG_DEADBAND     = 3'd5;
  localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd6;
  localparam logic [2:0] REG_DEFAULT_DT   = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MDIFF,
    S_DLOAD,
    S_DIV,
    S_MF1,
    S_MF2,
    S_FADD,
    S_MC1,
    S_MC2,
    S_CADD,
    S_REF,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic               action;
    logic signed [15:0] desired_roll;
    logic signed [15:0] desired_pitch;
    logic signed [15:0] measured_roll;
    logic signed [15:0] measured_pitch;
    logic        [15:0] dt_us;
  } in_word_t;

endpackage

FILE: hdl/dapc_if.sv
// Handshake interfaces of the input and result channels.
interface dapc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] desired_roll;
  logic signed [15:0] desired_pitch;
  logic signed [15:0] measured_roll;
  logic signed [15:0] measured_pitch;
  logic        [15:0] dt_us;

  modport source (
    output valid, action, desired_roll, desired_pitch, measured_roll, measured_pitch, dt_us,
    input  ready
  );
  modport sink (
    input  valid, action, desired_roll, desired_pitch, measured_roll, measured_pitch, dt_us,
    output ready
  );
endinterface

interface dapc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_reference;
  logic signed [15:0] pitch_reference;

  modport source (
    output valid, roll_reference, pitch_reference,
    input  ready
  );
  modport sink (
    input  valid, roll_reference, pitch_reference,
    output ready
  );
endinterface

FILE: hdl/dapc_mac.sv
// Shared signed multiplier with a registered product and an accumulator.
module dapc_mac (
  input  logic                               clk,
  input  dapc_pkg::mac_ctrl_t                ctrl,
  input  logic signed [dapc_pkg::OPA_W-1:0]  op_a,
  input  logic signed [dapc_pkg::OPB_W-1:0]  op_b,
  output logic signed [dapc_pkg::PROD_W-1:0] prod_r,
  output logic signed [dapc_pkg::PROD_W-1:0] acc_r
);

  logic signed [dapc_pkg::OPA_W+dapc_pkg::OPB_W-1:0] prod_full;

  assign prod_full = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_full[dapc_pkg::PROD_W-1:0];
    end
    unique case (ctrl.acc_op)
      dapc_pkg::ACC_HOLD: acc_r <= acc_r;
      dapc_pkg::ACC_LOAD: acc_r <= prod_r;
      dapc_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
      default:            acc_r <= acc_r;
    endcase
  end

endmodule

FILE: hdl/dapc_div.sv
// Restoring unsigned divider that retires two quotient bits per cycle.
module dapc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [dapc_pkg::DIV_W-1:0]        dividend,
  input  logic [dapc_pkg::DVS_W-1:0]        divisor,
  output logic [dapc_pkg::DIV_W-1:0]        quotient,
  output dapc_pkg::div_stat_t               stat
);

  localparam int DW = dapc_pkg::DVS_W;

  logic [dapc_pkg::DIV_W-1:0]     q_r, q_nxt;
  logic [DW-1:0]                  rem_r, rem_mid, rem_nxt;
  logic [DW-1:0]                  dvs_r;
  logic [dapc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           qb_hi, qb_lo;
  logic                           last;

  // One restoring step: the remainder stays below the divisor, so it fits DW bits.
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nbit,
                                           input logic [DW-1:0] dvs);
    logic [DW:0] t;
    logic [DW:0] d;
    t = {rem, nbit};
    d = {1'b0, dvs};
    if (t >= d) begin
      div_step = {1'b1, DW'(t - d)};
    end else begin
      div_step = {1'b0, t[DW-1:0]};
    end
  endfunction

  always_comb begin
    {qb_hi, rem_mid} = div_step(rem_r, q_r[dapc_pkg::DIV_W-1], dvs_r);
    {qb_lo, rem_nxt} = div_step(rem_mid, q_r[dapc_pkg::DIV_W-2], dvs_r);
    q_nxt = {q_r[dapc_pkg::DIV_W-3:0], qb_hi, qb_lo};
  end

  assign last = (cnt_r == dapc_pkg::DIV_CNT_W'(dapc_pkg::DIV_ITER - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= !last;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = busy_r && last;

endmodule

FILE: hdl/dual_axis_pd_attitude_ctrl.sv
// Top level: configuration registers, sequencer and per-axis state of the PD controller.
// An update word runs both axes in turn, roll then pitch, through the shared sequencer;
// per axis the scaled error difference passes through the two-bit-per-cycle divider; the result
// is held valid while out_ch.ready is low, which delays the acceptance of the next word.
// A reset-action word shows its result in the next cycle. One word is in flight at a time.
// rst_n is synchronous: it restores register defaults and clears references and history.
module dual_axis_pd_attitude_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  dapc_in_if.sink      in_ch,
  dapc_out_if.source   out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int PW = dapc_pkg::PROD_W;

  // Configuration registers.
  logic [15:0] kp_roll_r, kp_pitch_r, kd_roll_r, kd_pitch_r;
  logic [12:0] alpha_r;
  logic [14:0] deadband_r, limit_r;
  logic [15:0] default_dt_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  dapc_pkg::state_t  state_r, state_nxt;
  dapc_pkg::in_word_t in_r;
  logic              ax_r;
  logic              in_acc;

  logic signed [15:0] ref_r      [2];
  logic signed [16:0] err_last_r [2];
  logic signed [31:0] filt_r     [2];
  logic signed [16:0] err_new_r;
  logic signed [17:0] diff_r;
  logic signed [31:0] deriv_r;
  logic               dsign_r;

  // Sequencer outputs.
  dapc_pkg::mac_ctrl_t           mac_ctrl;
  logic signed [dapc_pkg::OPA_W-1:0] op_a;
  logic signed [dapc_pkg::OPB_W-1:0] op_b;
  logic                          div_start;
  logic                          in_ready;
  logic                          out_valid;

  logic signed [PW-1:0] prod_r, acc_r;
  logic [dapc_pkg::DIV_W-1:0] div_q;
  dapc_pkg::div_stat_t        div_st;

  // Datapath nets.
  logic signed [15:0] des, meas;
  logic signed [16:0] err_raw, err_mag, err_z;
  logic signed [17:0] diff;
  logic        [15:0] dt_sel;
  logic        [12:0] alpha_c;
  logic signed [PW-1:0] prod_abs;
  logic        [31:0] q_pos, q_neg, deriv_new;
  logic signed [PW-1:0] filt_sh;
  logic signed [31:0] filt_sat;
  logic signed [PW-1:0] ctrl_sh, ref_sum, lim_p, lim_n;
  logic signed [15:0] ref_new;
  logic signed [15:0] lim16;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_roll_r    <= 16'd1229;
      kp_pitch_r   <= 16'd1229;
      kd_roll_r    <= 16'd205;
      kd_pitch_r   <= 16'd205;
      alpha_r      <= 13'd3277;
      deadband_r   <= 15'd256;
      limit_r      <= 15'd3072;
      default_dt_r <= 16'd500;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dapc_pkg::REG_KP_ROLL:      kp_roll_r    <= cfg_pwdata[15:0];
        dapc_pkg::REG_KP_PITCH:     kp_pitch_r   <= cfg_pwdata[15:0];
        dapc_pkg::REG_KD_ROLL:      kd_roll_r    <= cfg_pwdata[15:0];
        dapc_pkg::REG_KD_PITCH:     kd_pitch_r   <= cfg_pwdata[15:0];
        dapc_pkg::REG_FILTER_ALPHA: alpha_r      <= cfg_pwdata[12:0];
        dapc_pkg::REG_DEADBAND:     deadband_r   <= cfg_pwdata[14:0];
        dapc_pkg::REG_OUTPUT_LIMIT: limit_r      <= cfg_pwdata[14:0];
        dapc_pkg::REG_DEFAULT_DT:   default_dt_r <= cfg_pwdata[15:0];
        default:                    default_dt_r <= default_dt_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dapc_pkg::REG_KP_ROLL:      cfg_prdata = {16'd0, kp_roll_r};
      dapc_pkg::REG_KP_PITCH:     cfg_prdata = {16'd0, kp_pitch_r};
      dapc_pkg::REG_KD_ROLL:      cfg_prdata = {16'd0, kd_roll_r};
      dapc_pkg::REG_KD_PITCH:     cfg_prdata = {16'd0, kd_pitch_r};
      dapc_pkg::REG_FILTER_ALPHA: cfg_prdata = {19'd0, alpha_r};
      dapc_pkg::REG_DEADBAND:     cfg_prdata = {17'd0, deadband_r};
      dapc_pkg::REG_OUTPUT_LIMIT: cfg_prdata = {17'd0, limit_r};
      dapc_pkg::REG_DEFAULT_DT:   cfg_prdata = {16'd0, default_dt_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------- shared units ----------------
  dapc_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r),
    .acc_r  (acc_r)
  );

  dapc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_abs[dapc_pkg::DIV_W-1:0]),
    .divisor  (dt_sel),
    .quotient (div_q),
    .stat     (div_st)
  );

  // ---------------- datapath ----------------
  always_comb begin
    des     = ax_r ? in_r.desired_pitch  : in_r.desired_roll;
    meas    = ax_r ? in_r.measured_pitch : in_r.measured_roll;
    err_raw = {des[15], des} - {meas[15], meas};
    err_mag = err_raw[16] ? -err_raw : err_raw;
    err_z   = ($unsigned(err_mag) < {2'b00, deadband_r}) ? 17'sd0 : err_raw;
    diff    = {err_z[16], err_z} - {err_last_r[ax_r][16], err_last_r[ax_r]};

    // A zero step selects the default step, and a zero default acts as one microsecond.
    if (in_r.dt_us != 16'd0) begin
      dt_sel = in_r.dt_us;
    end else if (default_dt_r != 16'd0) begin
      dt_sel = default_dt_r;
    end else begin
      dt_sel = 16'd1;
    end

    alpha_c  = (alpha_r > dapc_pkg::ALPHA_ONE) ? dapc_pkg::ALPHA_ONE : alpha_r;
    prod_abs = prod_r[PW-1] ? -prod_r : prod_r;

    // Quotient magnitude saturated to the signed 32-bit range, sign restored.
    q_pos     = (div_q > 38'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
    q_neg     = (div_q > 38'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
    deriv_new = dsign_r ? q_neg : q_pos;

    filt_sh = acc_r >>> dapc_pkg::ALPHA_FRAC_BITS;
    if ((&filt_sh[PW-1:31]) || !(|filt_sh[PW-1:31])) begin
      filt_sat = filt_sh[31:0];
    end else begin
      filt_sat = filt_sh[PW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end

    ctrl_sh = acc_r >>> dapc_pkg::GAIN_FRAC_BITS;
    ref_sum = {{(PW-16){ref_r[ax_r][15]}}, ref_r[ax_r]} + ctrl_sh;
    lim_p   = {{(PW-15){1'b0}}, limit_r};
    lim_n   = -lim_p;
    if (ref_sum > lim_p) begin
      ref_new = lim_p[15:0];
    end else if (ref_sum < lim_n) begin
      ref_new = lim_n[15:0];
    end else begin
      ref_new = ref_sum[15:0];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dapc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = dapc_pkg::ACC_HOLD;
    op_a            = '0;
    op_b            = '0;
    div_start       = 1'b0;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    unique case (state_r)
      dapc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = in_ch.action ? dapc_pkg::S_OUT : dapc_pkg::S_ERR;
        end
      end
      dapc_pkg::S_ERR: begin
        state_nxt = dapc_pkg::S_MDIFF;
      end
      dapc_pkg::S_MDIFF: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = dapc_pkg::OPA_W'(diff_r);
        op_b            = dapc_pkg::US_PER_S;
        state_nxt       = dapc_pkg::S_DLOAD;
      end
      dapc_pkg::S_DLOAD: begin
        div_start = 1'b1;
        state_nxt = dapc_pkg::S_DIV;
      end
      dapc_pkg::S_DIV: begin
        if (div_st.done) begin
          state_nxt = dapc_pkg::S_MF1;
        end
      end
      dapc_pkg::S_MF1: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = dapc_pkg::OPA_W'(filt_r[ax_r]);
        op_b            = $signed({8'd0, alpha_c});
        state_nxt       = dapc_pkg::S_MF2;
      end
      dapc_pkg::S_MF2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = dapc_pkg::ACC_LOAD;
        op_a            = dapc_pkg::OPA_W'(deriv_r);
        op_b            = $signed({8'd0, 13'(dapc_pkg::ALPHA_ONE - alpha_c)});
        state_nxt       = dapc_pkg::S_FADD;
      end
      dapc_pkg::S_FADD: begin
        mac_ctrl.acc_op = dapc_pkg::ACC_ADD;
        state_nxt       = dapc_pkg::S_MC1;
      end
      dapc_pkg::S_MC1: begin
        mac_ctrl.mul_en = 1'b1;
        op_a            = dapc_pkg::OPA_W'(err_new_r);
        op_b            = $signed({5'd0, (ax_r ? kp_pitch_r : kp_roll_r)});
        state_nxt       = dapc_pkg::S_MC2;
      end
      dapc_pkg::S_MC2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = dapc_pkg::ACC_LOAD;
        op_a            = dapc_pkg::OPA_W'(filt_r[ax_r]);
        op_b            = $signed({5'd0, (ax_r ? kd_pitch_r : kd_roll_r)});
        state_nxt       = dapc_pkg::S_CADD;
      end
      dapc_pkg::S_CADD: begin
        mac_ctrl.acc_op = dapc_pkg::ACC_ADD;
        state_nxt       = dapc_pkg::S_REF;
      end
      dapc_pkg::S_REF: begin
        state_nxt = ax_r ? dapc_pkg::S_OUT : dapc_pkg::S_ERR;
      end
      dapc_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = dapc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dapc_pkg::S_IDLE;
      end
    endcase
  end

  assign in_acc = in_ready && in_ch.valid;

  // Per-axis controller state, cleared by reset; the reset action clears the history and loads the references.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        ref_r[i]      <= '0;
        err_last_r[i] <= '0;
        filt_r[i]     <= '0;
      end
    end else begin
      if (in_acc) begin
        ax_r <= 1'b0;
        if (in_ch.action) begin
          ref_r[0] <= in_ch.desired_roll;
          ref_r[1] <= in_ch.desired_pitch;
          for (int i = 0; i < 2; i++) begin
            err_last_r[i] <= '0;
            filt_r[i]     <= '0;
          end
        end
      end
      if (state_r == dapc_pkg::S_MC1) begin
        filt_r[ax_r] <= filt_sat;
      end
      if (state_r == dapc_pkg::S_REF) begin
        ref_r[ax_r]      <= ref_new;
        err_last_r[ax_r] <= err_new_r;
        ax_r             <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r.action         <= in_ch.action;
      in_r.desired_roll   <= in_ch.desired_roll;
      in_r.desired_pitch  <= in_ch.desired_pitch;
      in_r.measured_roll  <= in_ch.measured_roll;
      in_r.measured_pitch <= in_ch.measured_pitch;
      in_r.dt_us          <= in_ch.dt_us;
    end
    if (state_r == dapc_pkg::S_ERR) begin
      err_new_r <= err_z;
      diff_r    <= diff;
    end
    if (state_r == dapc_pkg::S_DLOAD) begin
      dsign_r <= prod_r[PW-1];
    end
    if (state_r == dapc_pkg::S_MF1) begin
      deriv_r <= deriv_new;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.roll_reference  = ref_r[0];
  assign out_ch.pitch_reference = ref_r[1];

  // ---------------- assertions ----------------
  assign lim16 = $signed({1'b0, limit_r});

  a_ready_excl_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while a result word is pending");

  a_reset_action_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.action) |=> out_ch.valid)
    else $error("reset action word did not produce a result in the next cycle");

  a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r == dapc_pkg::S_DIV))
    else $error("divider busy outside its sequencer step");

  a_ref_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dapc_pkg::S_REF && ax_r) |=>
      (ref_r[0] <= lim16 && ref_r[0] >= -lim16 && ref_r[1] <= lim16 && ref_r[1] >= -lim16))
    else $error("updated reference outside the output limit");

endmodule

FILE: tb/dual_axis_pd_attitude_ctrl_tb.sv
// Self-checking testbench of the two-axis PD attitude controller with a predicting scoreboard.
module dual_axis_pd_attitude_ctrl_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint I32_MAX = (longint'(1) <<< 31) - 1;
  localparam longint I32_MIN = -(longint'(1) <<< 31);
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } ref_pair_t;

  // Tracks the controller state and queues the reference pair each accepted word yields.
  class attitude_ref_predictor;
    longint gain_p[2];
    longint gain_d[2];
    longint alpha_q12;
    longint dead_q8;
    longint limit_q8;
    longint dt_default;
    longint ref_q8[2];
    longint err_prev[2];
    longint deriv_filt[2];
    ref_pair_t pending_refs[$];
    int ref_mismatches;

    function new();
      gain_p = '{1229, 1229};
      gain_d = '{205, 205};
      alpha_q12 = 3277;
      dead_q8 = 256;
      limit_q8 = 3072;
      dt_default = 500;
      ref_q8 = '{0, 0};
      err_prev = '{0, 0};
      deriv_filt = '{0, 0};
      ref_mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        dapc_pkg::REG_KP_ROLL:      gain_p[0] = val[15:0];
        dapc_pkg::REG_KP_PITCH:     gain_p[1] = val[15:0];
        dapc_pkg::REG_KD_ROLL:      gain_d[0] = val[15:0];
        dapc_pkg::REG_KD_PITCH:     gain_d[1] = val[15:0];
        dapc_pkg::REG_FILTER_ALPHA: alpha_q12 = val[12:0];
        dapc_pkg::REG_DEADBAND:     dead_q8 = val[14:0];
        dapc_pkg::REG_OUTPUT_LIMIT: limit_q8 = val[14:0];
        dapc_pkg::REG_DEFAULT_DT:   dt_default = val[15:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void track_axis(int a, longint desired, longint measured, longint dt);
      longint err;
      longint mag;
      longint deriv;
      longint alpha;
      longint mix;
      longint ctrl;
      err = desired - measured;
      mag = (err < 0) ? -err : err;
      if (mag < dead_q8) err = 0;
      // Integer division truncates toward zero, as the divider does.
      deriv = sat(((err - err_prev[a]) * longint'(dapc_pkg::US_PER_S)) / dt, I32_MIN, I32_MAX);
      alpha = (alpha_q12 > longint'(dapc_pkg::ALPHA_ONE)) ? longint'(dapc_pkg::ALPHA_ONE)
                                                          : alpha_q12;
      mix = alpha * deriv_filt[a] + (longint'(dapc_pkg::ALPHA_ONE) - alpha) * deriv;
      deriv_filt[a] = sat(mix >>> dapc_pkg::ALPHA_FRAC_BITS, I32_MIN, I32_MAX);
      ctrl = (gain_p[a] * err + gain_d[a] * deriv_filt[a]) >>> dapc_pkg::GAIN_FRAC_BITS;
      ref_q8[a] = sat(sat(ref_q8[a] + ctrl, -limit_q8, limit_q8), -32768, 32767);
      err_prev[a] = err;
    endfunction

    function void accept_command(dapc_pkg::in_word_t w);
      longint dt;
      ref_pair_t exp_refs;
      if (w.action) begin
        ref_q8[0] = longint'($signed(w.desired_roll));
        ref_q8[1] = longint'($signed(w.desired_pitch));
        err_prev = '{0, 0};
        deriv_filt = '{0, 0};
      end else begin
        dt = w.dt_us;
        if (dt == 0) dt = dt_default;
        if (dt == 0) dt = 1;
        track_axis(0, longint'($signed(w.desired_roll)),
                   longint'($signed(w.measured_roll)), dt);
        track_axis(1, longint'($signed(w.desired_pitch)),
                   longint'($signed(w.measured_pitch)), dt);
      end
      exp_refs.roll = ref_q8[0][15:0];
      exp_refs.pitch = ref_q8[1][15:0];
      pending_refs.push_back(exp_refs);
    endfunction

    function void compare_refs(logic signed [15:0] roll, logic signed [15:0] pitch);
      ref_pair_t exp_refs;
      if (pending_refs.size() == 0) begin
        ref_mismatches++;
        if (ref_mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word roll=%0d pitch=%0d", $realtime, roll, pitch);
        return;
      end
      exp_refs = pending_refs.pop_front();
      if (roll !== exp_refs.roll || pitch !== exp_refs.pitch) begin
        ref_mismatches++;
        if (ref_mismatches <= MAX_REPORTS)
          $display("%0t: reference mismatch: expected roll=%0d pitch=%0d, got roll=%0d pitch=%0d",
                   $realtime, exp_refs.roll, exp_refs.pitch, roll, pitch);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  bit          idle_on;
  int          stall_left;

  attitude_ref_predictor model;

  dapc_in_if  in_bus ();
  dapc_out_if out_bus ();

  dual_axis_pd_attitude_ctrl DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // The result side stalls in random bursts while idling is enabled.
  initial begin
    out_bus.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      model.compare_refs(out_bus.roll_reference, out_bus.pitch_reference);
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    model.set_reg(idx, val);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic send_cmd(input bit act, input int dr, input int dp, input int mr,
                          input int mp, input int dt);
    dapc_pkg::in_word_t w;
    w.action = act;
    w.desired_roll = dr[15:0];
    w.desired_pitch = dp[15:0];
    w.measured_roll = mr[15:0];
    w.measured_pitch = mp[15:0];
    w.dt_us = dt[15:0];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.action = w.action;
    in_bus.desired_roll = w.desired_roll;
    in_bus.desired_pitch = w.desired_pitch;
    in_bus.measured_roll = w.measured_roll;
    in_bus.measured_pitch = w.measured_pitch;
    in_bus.dt_us = w.dt_us;
    do @(posedge clk); while (!in_bus.ready);
    model.accept_command(w);
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  // Holds off new words until every outstanding reference pair has come back.
  task automatic drain();
    while (model.pending_refs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 9))
      0, 1: return int'($urandom_range(0, 65535));
      2: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 15))
                                     : -32768 + int'($urandom_range(0, 15));
      default: return int'($urandom_range(0, 8192)) - 4096;
    endcase
  endfunction

  function automatic int rand_dt();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7: return int'($urandom_range(1, 20));
      8, 9: return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(100, 2000));
    endcase
  endfunction

  function automatic logic [31:0] rand_reg_value(logic [2:0] idx);
    logic [31:0] mask;
    logic [31:0] dflt;
    logic [31:0] typical;
    case (idx)
      dapc_pkg::REG_KP_ROLL, dapc_pkg::REG_KP_PITCH: begin
        mask = 32'hFFFF; dflt = 1229; typical = $urandom_range(0, 8191);
      end
      dapc_pkg::REG_KD_ROLL, dapc_pkg::REG_KD_PITCH: begin
        mask = 32'hFFFF; dflt = 205; typical = $urandom_range(0, 2047);
      end
      dapc_pkg::REG_FILTER_ALPHA: begin
        mask = 32'h1FFF; dflt = 3277; typical = $urandom_range(0, 4200);
      end
      dapc_pkg::REG_DEADBAND: begin
        mask = 32'h7FFF; dflt = 256; typical = $urandom_range(0, 1024);
      end
      dapc_pkg::REG_OUTPUT_LIMIT: begin
        mask = 32'h7FFF; dflt = 3072; typical = $urandom_range(0, 12000);
      end
      default: begin
        mask = 32'hFFFF; dflt = 500; typical = $urandom_range(1, 4000);
      end
    endcase
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return mask;
      2: return dflt;
      // Upper bits beyond the register width are expected to be dropped.
      3: return typical | ($urandom() & ~mask);
      default: return typical;
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    int des_r;
    int des_p;
    model = new();
    rst_n = 1'b0;
    idle_on = 1'b1;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = 1'b0;
    in_bus.desired_roll = '0;
    in_bus.desired_pitch = '0;
    in_bus.measured_roll = '0;
    in_bus.measured_pitch = '0;
    in_bus.dt_us = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed words under the reset defaults.
    send_cmd(1'b1, 32767, -32768, 1234, -77, 1234);
    send_cmd(1'b0, 100, -100, 100, -100, 0);
    send_cmd(1'b0, 256, 255, 0, 0, 500);
    send_cmd(1'b0, 32767, -32768, -32768, 32767, 1);
    send_cmd(1'b0, -32768, 32767, 32767, -32768, 65535);
    send_cmd(1'b1, 0, 0, 32767, 32767, 0);

    // Zero default step, alpha above one, no deadband, widest limit, largest gains.
    drain();
    cfg_write(dapc_pkg::REG_DEFAULT_DT, 32'd0);
    cfg_write(dapc_pkg::REG_FILTER_ALPHA, 32'h1FFF);
    cfg_write(dapc_pkg::REG_DEADBAND, 32'd0);
    cfg_write(dapc_pkg::REG_OUTPUT_LIMIT, 32'h7FFF);
    cfg_write(dapc_pkg::REG_KP_ROLL, 32'hFFFF);
    cfg_write(dapc_pkg::REG_KP_PITCH, 32'hFFFF);
    cfg_write(dapc_pkg::REG_KD_ROLL, 32'hFFFF);
    cfg_write(dapc_pkg::REG_KD_PITCH, 32'hFFFF);
    send_cmd(1'b0, 3, -3, 0, 0, 0);
    send_cmd(1'b0, 32767, -32768, -32768, 32767, 0);
    send_cmd(1'b0, -32768, 32767, 32767, -32768, 1);
    send_cmd(1'b1, -32768, 32767, 0, 0, 9);
    send_cmd(1'b0, 0, 0, 0, 0, 7);

    // Zero roll proportional and pitch derivative gains, zero limit, widest deadband, alpha at zero.
    drain();
    cfg_write(dapc_pkg::REG_FILTER_ALPHA, 32'd0);
    cfg_write(dapc_pkg::REG_OUTPUT_LIMIT, 32'd0);
    cfg_write(dapc_pkg::REG_DEADBAND, 32'h7FFF);
    cfg_write(dapc_pkg::REG_KP_ROLL, 32'd0);
    cfg_write(dapc_pkg::REG_KD_PITCH, 32'd0);
    cfg_write(dapc_pkg::REG_DEFAULT_DT, 32'hFFFF);
    send_cmd(1'b0, 32767, -32768, -32768, 32767, 0);
    send_cmd(1'b0, 100, -32768, -32768, 100, 3);

    // Smallest nonzero settings with alpha exactly one.
    drain();
    cfg_write(dapc_pkg::REG_FILTER_ALPHA, 32'd4096);
    cfg_write(dapc_pkg::REG_DEADBAND, 32'd1);
    cfg_write(dapc_pkg::REG_OUTPUT_LIMIT, 32'd1);
    cfg_write(dapc_pkg::REG_KP_PITCH, 32'd1);
    cfg_write(dapc_pkg::REG_KD_ROLL, 32'd1);
    cfg_write(dapc_pkg::REG_DEFAULT_DT, 32'd1);
    send_cmd(1'b0, 20000, -20000, -1, 1, 0);
    send_cmd(1'b0, -20000, 20000, 1, -1, 2);

    // Random phases, each under a fresh setting; the fourth and the last run without idling.
    for (phase = 0; phase < 7; phase++) begin
      drain();
      idle_on = (phase != 3) && (phase != 6);
      for (n = 0; n < 8; n++)
        cfg_write(n[2:0], rand_reg_value(n[2:0]));
      for (n = 0; n < 100; n++) begin
        des_r = rand_angle();
        des_p = rand_angle();
        if ($urandom_range(0, 12) == 0) begin
          send_cmd(1'b1, des_r, des_p, rand_angle(), rand_angle(), rand_dt());
        end else if ($urandom_range(0, 1) == 0) begin
          // Measured angles tracking the setpoint keep errors near the deadband.
          send_cmd(1'b0, des_r, des_p, des_r + int'($urandom_range(0, 1024)) - 512,
                   des_p + int'($urandom_range(0, 1024)) - 512, rand_dt());
        end else begin
          send_cmd(1'b0, des_r, des_p, rand_angle(), rand_angle(), rand_dt());
        end
      end
    end

    while (model.pending_refs.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (model.ref_mismatches == 0 && model.pending_refs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
